### hdl/ovls_pkg.sv
// Package for the ordered value list store: sizes, action and status codes,
// and the request and response payload structs.
// No dependencies.
package ovls_pkg;

	// Storage sizes
	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths fixed by the interface
	localparam int ACTION_W = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_SEARCH     = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INS_FRONT  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_INS_END    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_REM_FRONT  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_REM_END    = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_REM_VALUE  = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] removed_value;
		logic [COUNT_W-1:0]        count;
	} rsp_t;

endpackage

### hdl/ovls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ovls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

### hdl/ordered_value_list_store.sv
// Channel   | Signals                      | Transfer when
// ----------+------------------------------+--------------------------
// request   | req_valid, req_ready, req    | req_valid & req_ready
// response  | rsp_valid, rsp_ready, rsp    | rsp_valid & rsp_ready
//
// One request at a time; entries live in a RAM with registered read, and one
// shared comparator and read/write pointer walk it one entry per cycle.
// Search and remove value scan from the front; remove front, remove end and a
// matched remove value move the later entries up; insert front first moves every
// entry down (not into an empty store). Insert end, a full or empty store and
// unused actions respond directly. Only a held output register causes a stall.
// Reset clears the entry count and all handshake state; the RAM is not cleared.
// A waiting response does not stop the next request: only a second finished
// result holds the sequencer until the output register is free.
// Depends on ovls_pkg and ovls_ram.
module ordered_value_list_store (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ovls_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ovls_pkg::rsp_t rsp
);
	import ovls_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_UP    = 6'b000100,
		S_DOWN  = 6'b001000,
		S_FRONT = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic pend_q, pend_d;
	logic rsp_valid_q, rsp_valid_d;

	logic [ACTION_W-1:0] act_q, act_d;
	logic [VALUE_W-1:0] val_q, val_d;
	logic [ADDR_W-1:0] ptr_q, ptr_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [VALUE_W-1:0] removed_q, removed_d;
	rsp_t rsp_q, rsp_d;

	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;
	logic [VALUE_W-1:0] ram_rdata;

	logic [CNT_W-1:0] cnt_last;
	logic cnt_empty, cnt_full;
	logic pend_last, hit;

	ovls_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(ptr_q),
		.rd_data(ram_rdata)
	);

	assign cnt_last  = cnt_q - CNT_W'(1);
	assign cnt_empty = (cnt_q == '0);
	assign cnt_full  = (cnt_q == CNT_W'(CAPACITY));
	assign pend_last = pend_q && (CNT_W'(pend_addr_q) == cnt_last);
	// Shared comparator: the entry read last cycle against the request value
	assign hit       = pend_q && (ram_rdata == val_q);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Sequencer: next state, pointers and RAM write
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		pend_d      = 1'b0;
		act_d       = act_q;
		val_d       = val_q;
		ptr_d       = ptr_q;
		pos_d       = pos_q;
		pend_addr_d = ptr_q;
		status_d    = status_q;
		removed_d   = removed_q;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = val_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					act_d     = req.action;
					val_d     = req.value;
					status_d  = ST_DONE;
					removed_d = '0;
					ptr_d     = '0;
					pos_d     = '0;
					state_d   = S_RESP;
					case (req.action)
						ACT_SEARCH, ACT_REM_VALUE: begin
							if (cnt_empty) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_SCAN;
							end
						end
						ACT_INS_FRONT: begin
							if (cnt_full) begin
								status_d = ST_FULL;
							end else if (cnt_empty) begin
								ram_we    = 1'b1;
								ram_wdata = req.value;
								cnt_d     = cnt_q + CNT_W'(1);
							end else begin
								ptr_d   = cnt_last[ADDR_W-1:0];
								state_d = S_DOWN;
							end
						end
						ACT_INS_END: begin
							if (cnt_full) begin
								status_d = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = cnt_q[ADDR_W-1:0];
								ram_wdata = req.value;
								cnt_d     = cnt_q + CNT_W'(1);
							end
						end
						ACT_REM_FRONT: begin
							if (cnt_empty) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_UP;
							end
						end
						ACT_REM_END: begin
							if (cnt_empty) begin
								status_d = ST_EMPTY;
							end else begin
								ptr_d   = cnt_last[ADDR_W-1:0];
								pos_d   = cnt_last[ADDR_W-1:0];
								state_d = S_UP;
							end
						end
						default: begin
							status_d = ST_DONE;
						end
					endcase
				end
			end
			// Walk from the front, comparing each entry as it arrives
			S_SCAN: begin
				if (hit) begin
					if (act_q == ACT_REM_VALUE) begin
						ptr_d   = pend_addr_q;
						pos_d   = pend_addr_q;
						state_d = S_UP;
					end else begin
						state_d = S_RESP;
					end
				end else if (pend_last) begin
					status_d = ST_NOT_FOUND;
					state_d  = S_RESP;
				end else begin
					pend_d = 1'b1;
					ptr_d  = ptr_q + ADDR_W'(1);
				end
			end
			// Take out the entry at pos and move later entries up one place
			S_UP: begin
				if (pend_q) begin
					if (pend_addr_q == pos_q) begin
						removed_d = ram_rdata;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = pend_addr_q - ADDR_W'(1);
						ram_wdata = ram_rdata;
					end
				end
				if (pend_last) begin
					cnt_d   = cnt_last;
					state_d = S_RESP;
				end else begin
					pend_d = 1'b1;
					ptr_d  = ptr_q + ADDR_W'(1);
				end
			end
			// Move every entry down one place, starting from the end
			S_DOWN: begin
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = pend_addr_q + ADDR_W'(1);
					ram_wdata = ram_rdata;
				end
				if (pend_q && pend_addr_q == '0) begin
					state_d = S_FRONT;
				end else begin
					pend_d = 1'b1;
					ptr_d  = ptr_q - ADDR_W'(1);
				end
			end
			// Place the new value at the front
			S_FRONT: begin
				ram_we    = 1'b1;
				ram_wdata = val_q;
				cnt_d     = cnt_q + CNT_W'(1);
				state_d   = S_RESP;
			end
			// Hold until the output register is free
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output register
	always_comb begin
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		if (state_q == S_RESP && (!rsp_valid_q || rsp_ready)) begin
			rsp_d.status        = status_q;
			rsp_d.removed_value = removed_q;
			rsp_d.count         = COUNT_W'(cnt_q);
			rsp_valid_d         = 1'b1;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			pend_q      <= pend_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		act_q       <= act_d;
		val_q       <= val_d;
		ptr_q       <= ptr_d;
		pos_q       <= pos_d;
		pend_addr_q <= pend_addr_d;
		status_q    <= status_d;
		removed_q   <= removed_d;
		rsp_q       <= rsp_d;
	end

endmodule

### hdl/ovls_checker.sv
// Port-level checks for the ordered value list store, and the bind that
// attaches them to the top level. Depends on ovls_pkg.
module ovls_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input ovls_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ovls_pkg::rsp_t rsp
);
	import ovls_pkg::*;

	// A stalled response holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// One request at a time: busy after each transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// Full is reported only with a full store
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.count == COUNT_W'(CAPACITY))
		else $error("full status with spare room");

	// Empty is reported only with nothing held and nothing removed
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == '0 && rsp.removed_value == '0)
		else $error("empty status inconsistent");

endmodule

bind ordered_value_list_store ovls_checker u_ovls_checker (.*);

### tb/sv/ordered_value_list_store_chk.sv
`timescale 1ns / 100ps
// Transfer checker for the ordered value list store: keeps its own list,
// predicts one response per request transfer and compares responses in order.
// Depends on ovls_pkg.
module ordered_value_list_store_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  ovls_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  ovls_pkg::rsp_t rsp,
	output int unsigned    fail_count,
	output int unsigned    pending
);
	import ovls_pkg::*;

	localparam int unsigned REPORT_LIMIT = 10;

	// Shadow of the stored list, front at index 0
	logic signed [VALUE_W-1:0] shadow_list[$];
	rsp_t                      expected_rsp_q[$];
	int unsigned               fails;
	int unsigned               rsp_seen;

	// Apply one action to the shadow list and return the response it yields
	function automatic rsp_t apply_list_action(input req_t item);
		rsp_t res;
		int   hit;
		res.status        = ST_DONE;
		res.removed_value = '0;
		hit               = -1;
		foreach (shadow_list[i]) begin
			if (hit < 0 && shadow_list[i] == item.value)
				hit = i;
		end
		case (item.action)
			ACT_SEARCH: begin
				if (shadow_list.size() == 0)
					res.status = ST_EMPTY;
				else if (hit < 0)
					res.status = ST_NOT_FOUND;
			end
			ACT_INS_FRONT: begin
				if (shadow_list.size() >= CAPACITY)
					res.status = ST_FULL;
				else
					shadow_list.push_front(item.value);
			end
			ACT_INS_END: begin
				if (shadow_list.size() >= CAPACITY)
					res.status = ST_FULL;
				else
					shadow_list.push_back(item.value);
			end
			ACT_REM_FRONT: begin
				if (shadow_list.size() == 0)
					res.status = ST_EMPTY;
				else
					res.removed_value = shadow_list.pop_front();
			end
			ACT_REM_END: begin
				if (shadow_list.size() == 0)
					res.status = ST_EMPTY;
				else
					res.removed_value = shadow_list.pop_back();
			end
			ACT_REM_VALUE: begin
				if (shadow_list.size() == 0) begin
					res.status = ST_EMPTY;
				end else if (hit < 0) begin
					res.status = ST_NOT_FOUND;
				end else begin
					res.removed_value = shadow_list[hit];
					shadow_list.delete(hit);
				end
			end
			// spare codes leave the list alone
			default: ;
		endcase
		res.count = COUNT_W'(shadow_list.size());
		return res;
	endfunction

	// Check responses first, then record the prediction for a new request
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsp_seen++;
				if (expected_rsp_q.size() == 0) begin
					fails++;
					if (fails <= REPORT_LIMIT)
						$display("%0t: response %0d arrived with nothing expected",
							$realtime, rsp_seen);
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (rsp.status !== exp_rsp.status ||
						rsp.removed_value !== exp_rsp.removed_value ||
						rsp.count !== exp_rsp.count) begin
						fails++;
						if (fails <= REPORT_LIMIT) begin
							$write("%0t: response %0d mismatch: expected status %0d ",
								$realtime, rsp_seen, exp_rsp.status);
							$display("removed %0d count %0d, got status %0d removed %0d count %0d",
								exp_rsp.removed_value, exp_rsp.count, rsp.status,
								rsp.removed_value, rsp.count);
						end
					end
				end
			end
			if (req_valid && req_ready)
				expected_rsp_q.push_back(apply_list_action(req));
		end
		fail_count <= fails;
		pending    <= expected_rsp_q.size();
	end

endmodule

### tb/sv/ordered_value_list_store_tb.sv
`timescale 1ns / 100ps
// Top of the ordered value list store testbench: clock, reset, request and
// response stimulus, watchdog and verdict.
// Depends on ovls_pkg, ordered_value_list_store and ordered_value_list_store_chk.
module ordered_value_list_store_tb;
	import ovls_pkg::*;

	localparam realtime     HALF_PERIOD    = 10ns;
	localparam int unsigned RESET_CYCLES   = 10;
	localparam int unsigned PHASE_ITEMS    = 350;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned STALL_LIMIT    = 4000;
	localparam int unsigned DRAIN_CYCLES   = 4 * CAPACITY;

	// Action codes the block treats as no operation
	localparam logic [ACTION_W-1:0] ACT_SPARE_A = ACT_REM_VALUE + 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SPARE_B = ACT_REM_VALUE + 3'd2;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	int unsigned fail_count;
	int unsigned pending;

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	logic        hold_off_go;
	int unsigned items_sent;

	// Recently inserted values, reused so searches and removals find matches
	logic signed [VALUE_W-1:0] recent_values[8];
	logic [2:0]                recent_idx;

	always #(HALF_PERIOD) clk = ~clk;

	ordered_value_list_store dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	ordered_value_list_store_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Offer one request, idling beforehand at the current rate; entered and left at a
	// falling edge
	task automatic send_item(input logic [ACTION_W-1:0] action,
		input logic signed [VALUE_W-1:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid  <= 1'b1;
		req.action <= action;
		req.value  <= value;
		if (action == ACT_INS_FRONT || action == ACT_INS_END) begin
			recent_values[recent_idx] = value;
			recent_idx++;
		end
		if (action <= ACT_REM_VALUE)
			items_sent++;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(3))
			0, 1: return recent_values[$urandom_range(7)];
			2: return VALUE_W'(int'($urandom_range(8)) - 4);
			default: return $urandom;
		endcase
	endfunction

	// Random bursts: fill runs, drain runs and mixed runs with random values
	task automatic run_random_phase(input int unsigned target);
		int unsigned            stop_at;
		int unsigned            kind;
		logic [ACTION_W-1:0]    action;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			kind = $urandom_range(9);
			repeat ($urandom_range(20, 3)) begin
				if (kind < 3) begin
					action = $urandom_range(1) ? ACT_INS_FRONT : ACT_INS_END;
				end else if (kind < 6) begin
					case ($urandom_range(3))
						0: action = ACT_REM_FRONT;
						1: action = ACT_REM_END;
						2: action = ACT_REM_VALUE;
						default: action = ACT_SEARCH;
					endcase
				end else if ($urandom_range(19) == 0) begin
					action = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
				end else begin
					action = ACTION_W'($urandom_range(ACT_REM_VALUE));
				end
				send_item(action, pick_value());
			end
		end
	endtask

	// Response side: random stalls, and one long hold-off to back the block up
	initial begin
		bit hold_off_done;
		hold_off_done = 1'b0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_go && !hold_off_done) begin
				hold_off_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// End the run when nothing transfers for too long
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[ordered_value_list_store] ERROR");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		hold_off_go = 1'b0;
		tx_idle_pct = 20;
		rx_idle_pct = 61;
		items_sent  = 0;
		recent_idx  = '0;
		foreach (recent_values[i])
			recent_values[i] = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list: search and all three removals
		send_item(ACT_SEARCH, '0);
		send_item(ACT_REM_FRONT, '0);
		send_item(ACT_REM_END, '1);
		send_item(ACT_REM_VALUE, '0);
		// remove end with a single entry held
		send_item(ACT_INS_END, 32'sh7fff_ffff);
		send_item(ACT_REM_END, '0);
		// extremes at both ends, then found and missed searches
		send_item(ACT_INS_FRONT, 32'sh8000_0000);
		send_item(ACT_INS_FRONT, -32'sd1);
		send_item(ACT_INS_END, '0);
		send_item(ACT_INS_END, 32'sh7fff_ffff);
		send_item(ACT_SEARCH, '0);
		send_item(ACT_SEARCH, 32'sd5);
		// remove value matching the front entry, then one with no match
		send_item(ACT_REM_VALUE, -32'sd1);
		send_item(ACT_REM_VALUE, 32'sd123);
		send_item(ACT_SPARE_A, 32'sh5555_aaaa);
		send_item(ACT_SPARE_B, 32'shaaaa_5555);
		send_item(ACT_REM_FRONT, '0);
		send_item(ACT_REM_END, '0);
		send_item(ACT_REM_FRONT, '0);

		run_random_phase(PHASE_ITEMS);
		tx_idle_pct = 61;
		rx_idle_pct = 20;
		run_random_phase(PHASE_ITEMS);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_off_go <= 1'b1;
		run_random_phase(PHASE_ITEMS);
		req_valid <= 1'b0;

		// drain outstanding responses, then allow for stray extras
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ordered_value_list_store] OK");
		else
			$display("[ordered_value_list_store] ERROR");
		$finish;
	end

endmodule

### filelist.f
hdl/ovls_pkg.sv
hdl/ovls_ram.sv
hdl/ordered_value_list_store.sv
hdl/ovls_checker.sv
tb/sv/ordered_value_list_store_chk.sv
tb/sv/ordered_value_list_store_tb.sv
